>>> rtl/core/lifna_pkg.sv
`timescale 1ns / 1ps

package lifna_pkg;

   // sizes
   localparam int NEURON_COUNT_DEFAULT = 1024;
   localparam int INDEX_W              = 10;
   localparam int COUNT_W              = 12;
   localparam int FRAC_W               = 17;   // unsigned q1.16 fraction, below two
   localparam int LEVEL_W              = 24;   // signed q8.16 potential
   localparam int Q_W                  = 32;   // stored q16.16 word
   localparam int Q_FRAC               = 16;
   localparam int SAT_IN_W             = 64;

   // stream and register port widths
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 16;
   localparam int RSP_PAD_W   = RSP_DATA_W - INDEX_W - 1;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_INPUT_INCREMENT      = 3'd0,
      CSR_CONDUCTANCE_DECAY    = 3'd1,
      CSR_LEAK_RATE            = 3'd2,
      CSR_LEAK_POTENTIAL       = 3'd3,
      CSR_THRESHOLD_RELAX_RATE = 3'd4,
      CSR_THRESHOLD_BASE       = 3'd5,
      CSR_THRESHOLD_PEAK       = 3'd6
   } csr_index_type;

   // register reset values
   localparam logic [FRAC_W-1:0]         RST_INPUT_INCREMENT      = 17'd0;
   localparam logic [FRAC_W-1:0]         RST_CONDUCTANCE_DECAY    = 17'd65536;
   localparam logic [FRAC_W-1:0]         RST_LEAK_RATE            = 17'd0;
   localparam logic signed [LEVEL_W-1:0] RST_LEAK_POTENTIAL       = 24'shC40000;  // -60.0
   localparam logic [FRAC_W-1:0]         RST_THRESHOLD_RELAX_RATE = 17'd0;
   localparam logic signed [LEVEL_W-1:0] RST_THRESHOLD_BASE       = 24'shCE0000;  // -50.0
   localparam logic signed [LEVEL_W-1:0] RST_THRESHOLD_PEAK       = 24'sh000000;

   // clamp a wide signed value to the 32 bit signed range
   function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SAT_IN_W-1:0] x);
      logic [SAT_IN_W-Q_W:0] top_bits;
      logic signed [Q_W-1:0] result;
      top_bits = x[SAT_IN_W-1:Q_W-1];
      if (top_bits == '0 || top_bits == '1) begin
         result = signed'(x[Q_W-1:0]);
      end else if (x[SAT_IN_W-1]) begin
         result = {1'b1, {(Q_W-1){1'b0}}};
      end else begin
         result = {1'b0, {(Q_W-1){1'b1}}};
      end
      return result;
   endfunction

endpackage

>>> rtl/core/lif_neuron_adaptive_threshold_unit.sv
`timescale 1ns / 1ps

// channel   dir  handshake                 payload
// req       in   req_tvalid / req_tready   neuron_index, input_count
// rsp       out  rsp_tvalid / rsp_tready   neuron_number, spike
// csr       in   csr_valid / csr_ready     csr_index, csr_wdata
//
// a request runs through the states read, calc, decay, gsat, pull, volt and done: req_tready
// falls at acceptance and rises again once done has loaded the response register, a length
// set by the chain of dependent multiplies after the single state memory read
// after reset a clearing pass writes zero to all NEURON_COUNT entries;
// req_tready stays low meanwhile, csr writes are taken as ever
// the response register parts the two sides: a new request is accepted while a
// response waits, and the last step holds until the response register is free

module lif_neuron_adaptive_threshold_unit #(
   parameter int NEURON_COUNT = lifna_pkg::NEURON_COUNT_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [lifna_pkg::REQ_DATA_W-1:0]   req_tdata,   // [9:0] neuron_index, [21:10] input_count
   // response stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [lifna_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // [9:0] neuron_number, [10] spike
   // register writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lifna_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [lifna_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int ADDR_W        = (NEURON_COUNT > 1) ? $clog2(NEURON_COUNT) : 1;
   localparam int CNT_W         = $clog2(NEURON_COUNT + 1);
   localparam int EXT_W         = (CNT_W > lifna_pkg::INDEX_W) ? CNT_W : lifna_pkg::INDEX_W;
   localparam int WORD_W        = 3 * lifna_pkg::Q_W;
   localparam int INC_PROD_W    = lifna_pkg::COUNT_W + lifna_pkg::FRAC_W;
   localparam int DIFF_W        = lifna_pkg::Q_W + 1;
   localparam int FRAC_S_W      = lifna_pkg::FRAC_W + 1;
   localparam int STEP_PROD_W   = DIFF_W + FRAC_S_W;
   localparam int STEP_W        = STEP_PROD_W - lifna_pkg::Q_FRAC;
   localparam int DECAY_PROD_W  = lifna_pkg::Q_W + FRAC_S_W;
   localparam int PULL_PROD_W   = 2 * lifna_pkg::Q_W;

   localparam logic [EXT_W-1:0]  COUNT_LIMIT = EXT_W'(NEURON_COUNT);
   localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(NEURON_COUNT - 1);

   // one memory word per neuron
   typedef struct packed {
      logic signed [lifna_pkg::Q_W-1:0] threshold;
      logic signed [lifna_pkg::Q_W-1:0] voltage;
      logic signed [lifna_pkg::Q_W-1:0] conductance;
   } neuron_word_type;

   typedef enum logic [8:0] {
      ST_CLEAR = 9'b000000001,
      ST_IDLE  = 9'b000000010,
      ST_READ  = 9'b000000100,
      ST_CALC  = 9'b000001000,
      ST_DECAY = 9'b000010000,
      ST_GSAT  = 9'b000100000,
      ST_PULL  = 9'b001000000,
      ST_VOLT  = 9'b010000000,
      ST_DONE  = 9'b100000000
   } seq_state_type;

   // sequencer
   seq_state_type state_ff, state_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   // request fields
   logic [lifna_pkg::INDEX_W-1:0] req_index;
   logic [lifna_pkg::COUNT_W-1:0] req_count;
   logic [EXT_W-1:0]              req_index_ext;
   logic                          req_accept;
   logic                          req_in_range;

   logic [lifna_pkg::INDEX_W-1:0] index_ff;
   logic [lifna_pkg::COUNT_W-1:0] count_ff;
   logic                          in_range_ff;

   // registers
   logic                                  csr_write;
   logic [lifna_pkg::FRAC_W-1:0]          input_increment_ff;
   logic [lifna_pkg::FRAC_W-1:0]          conductance_decay_ff;
   logic [lifna_pkg::FRAC_W-1:0]          leak_rate_ff;
   logic signed [lifna_pkg::LEVEL_W-1:0]  leak_potential_ff;
   logic [lifna_pkg::FRAC_W-1:0]          threshold_relax_rate_ff;
   logic signed [lifna_pkg::LEVEL_W-1:0]  threshold_base_ff;
   logic signed [lifna_pkg::LEVEL_W-1:0]  threshold_peak_ff;

   // memory port
   logic                  ram_wr_en;
   logic [ADDR_W-1:0]     ram_wr_addr;
   logic [WORD_W-1:0]     ram_wr_data;
   logic [WORD_W-1:0]     ram_rd_data;
   neuron_word_type       old_word;
   neuron_word_type       new_word;

   // datapath
   logic [INC_PROD_W-1:0]            inc_prod_ff, inc_prod_in;
   logic signed [DIFF_W-1:0]         leak_diff;
   logic signed [DIFF_W-1:0]         relax_diff;
   logic signed [STEP_PROD_W-1:0]    leak_prod_ff, leak_prod_in;
   logic signed [STEP_PROD_W-1:0]    relax_prod_ff, relax_prod_in;
   logic signed [lifna_pkg::Q_W-1:0] g_inc_ff, g_inc_in;
   logic signed [STEP_W-1:0]         leak_ff, leak_in;
   logic signed [lifna_pkg::Q_W-1:0] th_relax_ff, th_relax_in;
   logic signed [DECAY_PROD_W-1:0]   decay_prod_ff, decay_prod_in;
   logic signed [lifna_pkg::Q_W-1:0] g_new_ff, g_new_in;
   logic signed [PULL_PROD_W-1:0]    pull_prod_ff, pull_prod_in;
   logic signed [lifna_pkg::Q_W-1:0] v_new_ff, v_new_in;
   logic                             spike_calc;
   logic signed [lifna_pkg::Q_W-1:0] th_final;

   // response register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [lifna_pkg::INDEX_W-1:0] rsp_number_ff;
   logic                          rsp_spike_ff;
   logic                          rsp_free;
   logic                          rsp_load;

   // ------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------
   assign req_index     = req_tdata[lifna_pkg::INDEX_W-1:0];
   assign req_count     = req_tdata[lifna_pkg::INDEX_W +: lifna_pkg::COUNT_W];
   assign req_index_ext = EXT_W'(req_index);
   assign req_in_range  = (req_index_ext < COUNT_LIMIT);
   assign req_tready    = (state_ff == ST_IDLE);
   assign req_accept    = req_tvalid & req_tready;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         index_ff    <= req_index;
         count_ff    <= req_count;
         in_range_ff <= req_in_range;
      end
   end

   // ------------------------------------------------------------------
   // register writes, taken at any time
   // ------------------------------------------------------------------
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         input_increment_ff      <= lifna_pkg::RST_INPUT_INCREMENT;
         conductance_decay_ff    <= lifna_pkg::RST_CONDUCTANCE_DECAY;
         leak_rate_ff            <= lifna_pkg::RST_LEAK_RATE;
         leak_potential_ff       <= lifna_pkg::RST_LEAK_POTENTIAL;
         threshold_relax_rate_ff <= lifna_pkg::RST_THRESHOLD_RELAX_RATE;
         threshold_base_ff       <= lifna_pkg::RST_THRESHOLD_BASE;
         threshold_peak_ff       <= lifna_pkg::RST_THRESHOLD_PEAK;
      end else if (csr_write) begin
         unique case (lifna_pkg::csr_index_type'(csr_index))
            lifna_pkg::CSR_INPUT_INCREMENT: begin
               input_increment_ff <= csr_wdata[lifna_pkg::FRAC_W-1:0];
            end
            lifna_pkg::CSR_CONDUCTANCE_DECAY: begin
               conductance_decay_ff <= csr_wdata[lifna_pkg::FRAC_W-1:0];
            end
            lifna_pkg::CSR_LEAK_RATE: begin
               leak_rate_ff <= csr_wdata[lifna_pkg::FRAC_W-1:0];
            end
            lifna_pkg::CSR_LEAK_POTENTIAL: begin
               leak_potential_ff <= signed'(csr_wdata[lifna_pkg::LEVEL_W-1:0]);
            end
            lifna_pkg::CSR_THRESHOLD_RELAX_RATE: begin
               threshold_relax_rate_ff <= csr_wdata[lifna_pkg::FRAC_W-1:0];
            end
            lifna_pkg::CSR_THRESHOLD_BASE: begin
               threshold_base_ff <= signed'(csr_wdata[lifna_pkg::LEVEL_W-1:0]);
            end
            lifna_pkg::CSR_THRESHOLD_PEAK: begin
               threshold_peak_ff <= signed'(csr_wdata[lifna_pkg::LEVEL_W-1:0]);
            end
            default: begin
               // unused index, write dropped
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------
   assign rsp_free = ~rsp_valid_ff | rsp_tready;
   assign rsp_load = (state_ff == ST_DONE) & rsp_free;

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_READ;
            end
         end
         ST_READ:  state_in = ST_CALC;
         ST_CALC:  state_in = ST_DECAY;
         ST_DECAY: state_in = ST_GSAT;
         ST_GSAT:  state_in = ST_PULL;
         ST_PULL:  state_in = ST_VOLT;
         ST_VOLT:  state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // ------------------------------------------------------------------
   // state memory: read on acceptance, written back in the last step;
   // requests run one at a time, so a read never meets a pending write
   // ------------------------------------------------------------------
   assign old_word = neuron_word_type'(ram_rd_data);

   assign new_word.threshold   = th_final;
   assign new_word.voltage     = v_new_ff;
   assign new_word.conductance = g_new_ff;

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = ADDR_W'(index_ff);
      ram_wr_data = new_word;
      if (state_ff == ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_addr_ff;
         ram_wr_data = '0;
      end else if (rsp_load && in_range_ff) begin
         ram_wr_en = 1'b1;
      end
   end

   lifna_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NEURON_COUNT)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (req_accept),
      .rd_addr (req_index_ext[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // ------------------------------------------------------------------
   // arithmetic, three multiplies in the read step, one in decay and one in pull, all q16.16 floored
   // ------------------------------------------------------------------
   // read step: input drive, leak and threshold relax products
   assign inc_prod_in   = INC_PROD_W'(count_ff) * INC_PROD_W'(input_increment_ff);
   assign leak_diff     = DIFF_W'(leak_potential_ff) - DIFF_W'(old_word.voltage);
   assign relax_diff    = DIFF_W'(threshold_base_ff) - DIFF_W'(old_word.threshold);
   assign leak_prod_in  = leak_diff * $signed({1'b0, leak_rate_ff});
   assign relax_prod_in = relax_diff * $signed({1'b0, threshold_relax_rate_ff});

   // calc step: add the drive, scale the leak, relax the threshold
   assign g_inc_in    = lifna_pkg::sat_q(lifna_pkg::SAT_IN_W'(old_word.conductance)
                                         + lifna_pkg::SAT_IN_W'($signed({1'b0, inc_prod_ff})));
   assign leak_in     = STEP_W'(leak_prod_ff >>> lifna_pkg::Q_FRAC);
   assign th_relax_in = lifna_pkg::sat_q(lifna_pkg::SAT_IN_W'(old_word.threshold)
                                         + lifna_pkg::SAT_IN_W'(relax_prod_ff >>> lifna_pkg::Q_FRAC));

   // conductance decay
   assign decay_prod_in = g_inc_ff * $signed({1'b0, conductance_decay_ff});
   assign g_new_in      = lifna_pkg::sat_q(lifna_pkg::SAT_IN_W'(decay_prod_ff >>> lifna_pkg::Q_FRAC));

   // shunting pull of conductance on voltage
   assign pull_prod_in = g_new_ff * old_word.voltage;
   assign v_new_in     = lifna_pkg::sat_q(lifna_pkg::SAT_IN_W'(old_word.voltage)
                                          + lifna_pkg::SAT_IN_W'(leak_ff)
                                          - lifna_pkg::SAT_IN_W'(pull_prod_ff >>> lifna_pkg::Q_FRAC));

   // spike against the threshold held before this step
   assign spike_calc = in_range_ff & (v_new_ff > old_word.threshold);
   assign th_final   = spike_calc ? lifna_pkg::Q_W'(threshold_peak_ff) : th_relax_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         inc_prod_ff   <= inc_prod_in;
         leak_prod_ff  <= leak_prod_in;
         relax_prod_ff <= relax_prod_in;
      end
      if (state_ff == ST_CALC) begin
         g_inc_ff    <= g_inc_in;
         leak_ff     <= leak_in;
         th_relax_ff <= th_relax_in;
      end
      if (state_ff == ST_DECAY) begin
         decay_prod_ff <= decay_prod_in;
      end
      if (state_ff == ST_GSAT) begin
         g_new_ff <= g_new_in;
      end
      if (state_ff == ST_PULL) begin
         pull_prod_ff <= pull_prod_in;
      end
      if (state_ff == ST_VOLT) begin
         v_new_ff <= v_new_in;
      end
   end

   // ------------------------------------------------------------------
   // response register
   // ------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_number_ff <= index_ff;
         rsp_spike_ff  <= spike_calc;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{lifna_pkg::RSP_PAD_W{1'b0}}, rsp_spike_ff, rsp_number_ff};

endmodule

>>> rtl/core/lifna_ram.sv
`timescale 1ns / 1ps

module lifna_ram #(
   parameter int WIDTH  = lifna_pkg::Q_W,
   parameter int DEPTH  = lifna_pkg::NEURON_COUNT_DEFAULT,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/lifna_checker.sv
`timescale 1ns / 1ps

module lifna_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [lifna_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   logic       req_fire;
   logic       rsp_fire;
   logic [1:0] pend_ff, pend_in;

   assign req_fire = req_tvalid & req_tready;
   assign rsp_fire = rsp_tvalid & rsp_tready;

   // requests accepted and not yet answered
   always_comb begin
      pend_in = pend_ff;
      if (req_fire && !rsp_fire) begin
         pend_in = pend_ff + 2'd1;
      end else if (rsp_fire && !req_fire) begin
         pend_in = pend_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // memory clearing pass keeps requests out right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request taken during clearing pass");

   // one request in work at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("request taken while another is in work");

   // every response answers an earlier request
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pend_ff != 2'd0)
      else $error("response without a pending request");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

endmodule

bind lif_neuron_adaptive_threshold_unit lifna_checker u_lifna_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> dv/tb_lif_neuron_adaptive_threshold_unit.sv
`timescale 1ns / 1ps

module tb_lif_neuron_adaptive_threshold_unit;

   localparam int  NEURONS          = lifna_pkg::NEURON_COUNT_DEFAULT;
   localparam int  CYCLE_LIMIT      = 600000;
   localparam int  HOLD_CYCLES      = 300;
   localparam int  DRAIN_CYCLES     = 16;
   localparam logic [lifna_pkg::CSR_INDEX_W-1:0] UNUSED_REG_INDEX = 3'd7;

   typedef struct packed {
      logic [lifna_pkg::INDEX_W-1:0] neuron;
      logic                          spike;
   } spike_result_type;

   logic                                  clock      = 1'b0;
   logic                                  reset      = 1'b1;
   logic                                  req_tvalid = 1'b0;
   logic                                  req_tready;
   logic [lifna_pkg::REQ_DATA_W-1:0]      req_tdata  = '0;
   logic                                  rsp_tvalid;
   logic                                  rsp_tready = 1'b0;
   logic [lifna_pkg::RSP_DATA_W-1:0]      rsp_tdata;
   logic                                  csr_valid  = 1'b0;
   logic                                  csr_ready;
   logic [lifna_pkg::CSR_INDEX_W-1:0]     csr_index  = '0;
   logic [lifna_pkg::CSR_DATA_W-1:0]      csr_wdata  = '0;

   lif_neuron_adaptive_threshold_unit #(
      .NEURON_COUNT(NEURONS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // shadow copy of the register file and the per-neuron state
   longint incr_q, decay_q, leak_q, leak_lvl, relax_q, base_lvl, peak_lvl;
   int     conductance_q [0:NEURONS-1];
   int     voltage_q     [0:NEURONS-1];
   int     threshold_q   [0:NEURONS-1];

   spike_result_type pending_spikes[$];
   int               mismatches  = 0;
   int               cycles      = 0;

   // idling controls
   bit req_gaps     = 1'b0;
   bit rsp_stalls   = 1'b0;
   bit hold_request = 1'b0;

   function automatic longint clamp_q(input longint x);
      if (x > 64'sd2147483647)  return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   // q16.16 product, floor rounding
   function automatic longint mul_q(input longint a, input longint b);
      return (a * b) >>> lifna_pkg::Q_FRAC;
   endfunction

   function automatic void clear_neuron_state();
      incr_q   = lifna_pkg::RST_INPUT_INCREMENT;
      decay_q  = lifna_pkg::RST_CONDUCTANCE_DECAY;
      leak_q   = lifna_pkg::RST_LEAK_RATE;
      leak_lvl = lifna_pkg::RST_LEAK_POTENTIAL;
      relax_q  = lifna_pkg::RST_THRESHOLD_RELAX_RATE;
      base_lvl = lifna_pkg::RST_THRESHOLD_BASE;
      peak_lvl = lifna_pkg::RST_THRESHOLD_PEAK;
      for (int i = 0; i < NEURONS; i++) begin
         conductance_q[i] = 0;
         voltage_q[i]     = 0;
         threshold_q[i]   = 0;
      end
   endfunction

   function automatic void apply_reg(input logic [lifna_pkg::CSR_INDEX_W-1:0] index,
                                     input logic [lifna_pkg::CSR_DATA_W-1:0] value);
      logic signed [lifna_pkg::LEVEL_W-1:0] lvl;
      lvl = signed'(value);
      case (index)
         lifna_pkg::CSR_INPUT_INCREMENT:      incr_q   = value[lifna_pkg::FRAC_W-1:0];
         lifna_pkg::CSR_CONDUCTANCE_DECAY:    decay_q  = value[lifna_pkg::FRAC_W-1:0];
         lifna_pkg::CSR_LEAK_RATE:            leak_q   = value[lifna_pkg::FRAC_W-1:0];
         lifna_pkg::CSR_LEAK_POTENTIAL:       leak_lvl = lvl;
         lifna_pkg::CSR_THRESHOLD_RELAX_RATE: relax_q  = value[lifna_pkg::FRAC_W-1:0];
         lifna_pkg::CSR_THRESHOLD_BASE:       base_lvl = lvl;
         lifna_pkg::CSR_THRESHOLD_PEAK:       peak_lvl = lvl;
         default: ;
      endcase
   endfunction

   // one time step of one neuron; returns the response it should produce
   function automatic spike_result_type advance_neuron(
         input logic [lifna_pkg::INDEX_W-1:0] idx,
         input logic [lifna_pkg::COUNT_W-1:0] cnt);
      spike_result_type r;
      longint           c, g, v, th, vn, thn;
      r.neuron = idx;
      r.spike  = 1'b0;
      if (idx < NEURONS) begin
         c  = cnt;
         g  = conductance_q[idx];
         v  = voltage_q[idx];
         th = threshold_q[idx];
         g  = clamp_q(g + c * incr_q);
         g  = clamp_q(mul_q(g, decay_q));
         vn = clamp_q(v + mul_q(leak_q, leak_lvl - v) - mul_q(g, v));
         r.spike = (vn > th);
         thn = clamp_q(th + mul_q(relax_q, base_lvl - th));
         if (r.spike) thn = peak_lvl;
         conductance_q[idx] = int'(g);
         voltage_q[idx]     = int'(vn);
         threshold_q[idx]   = int'(thn);
      end
      return r;
   endfunction

   // cycle limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("lif_neuron_adaptive_threshold_unit: mismatch");
         $finish;
      end
   end

   // response side: random stall bursts plus one long hold-off on request
   initial begin
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end else if (rsp_stalls && stall_left == 0 && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 14);
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // compare each accepted response with the oldest expected one
   always @(posedge clock) begin
      spike_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_spikes.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected response: neuron %0d spike %0b",
                        rsp_tdata[lifna_pkg::INDEX_W-1:0], rsp_tdata[lifna_pkg::INDEX_W]);
            mismatches++;
         end else begin
            want = pending_spikes.pop_front();
            if (rsp_tdata[lifna_pkg::INDEX_W-1:0] !== want.neuron
                || rsp_tdata[lifna_pkg::INDEX_W] !== want.spike) begin
               if (mismatches < 10)
                  $display("response differs: expected neuron %0d spike %0b, got %0d spike %0b",
                           want.neuron, want.spike,
                           rsp_tdata[lifna_pkg::INDEX_W-1:0], rsp_tdata[lifna_pkg::INDEX_W]);
               mismatches++;
            end
         end
      end
   end

   // valid is left high for a following write; the caller lowers it
   task automatic write_reg(input logic [lifna_pkg::CSR_INDEX_W-1:0] index,
                            input logic [lifna_pkg::CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      apply_reg(index, value);
   endtask

   task automatic program_regs(input int incr, input int decay, input int leak,
                               input int lpot, input int relax, input int base,
                               input int peak);
      write_reg(lifna_pkg::CSR_INPUT_INCREMENT,      incr[lifna_pkg::CSR_DATA_W-1:0]);
      write_reg(lifna_pkg::CSR_CONDUCTANCE_DECAY,    decay[lifna_pkg::CSR_DATA_W-1:0]);
      write_reg(lifna_pkg::CSR_LEAK_RATE,            leak[lifna_pkg::CSR_DATA_W-1:0]);
      write_reg(lifna_pkg::CSR_LEAK_POTENTIAL,       lpot[lifna_pkg::CSR_DATA_W-1:0]);
      write_reg(lifna_pkg::CSR_THRESHOLD_RELAX_RATE, relax[lifna_pkg::CSR_DATA_W-1:0]);
      write_reg(lifna_pkg::CSR_THRESHOLD_BASE,       base[lifna_pkg::CSR_DATA_W-1:0]);
      write_reg(lifna_pkg::CSR_THRESHOLD_PEAK,       peak[lifna_pkg::CSR_DATA_W-1:0]);
      csr_valid <= 1'b0;
   endtask

   // offer one request; valid stays high unless a gap follows
   task automatic offer_update(input logic [lifna_pkg::INDEX_W-1:0] idx,
                               input logic [lifna_pkg::COUNT_W-1:0] cnt);
      req_tvalid <= 1'b1;
      req_tdata  <= lifna_pkg::REQ_DATA_W'({cnt, idx});
      do @(posedge clock); while (!req_tready);
      pending_spikes.push_back(advance_neuron(idx, cnt));
      if (req_gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   // registers may only change once every outstanding response is back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_spikes.size() != 0) @(posedge clock);
   endtask

   // state is all zero after the clearing pass, so nothing spikes
   task automatic test_reset_state();
      offer_update(10'd0, 12'd0);
      offer_update(10'd999, 12'hFFF);
      offer_update(10'd1000, 12'hFFF);
      offer_update(10'd1023, 12'hFFF);   // top of the index range
      offer_update(10'd512, 12'd1);
      wait_drained();
   endtask

   // register values beyond range, unknown register, saturation both ways
   task automatic test_high_extremes();
      write_reg(lifna_pkg::CSR_INPUT_INCREMENT,      24'hFFFFFF);
      write_reg(lifna_pkg::CSR_CONDUCTANCE_DECAY,    24'h01FFFF);
      write_reg(lifna_pkg::CSR_LEAK_RATE,            24'h010000);
      write_reg(lifna_pkg::CSR_LEAK_POTENTIAL,       24'h7FFFFF);
      write_reg(lifna_pkg::CSR_THRESHOLD_RELAX_RATE, 24'h010000);
      write_reg(lifna_pkg::CSR_THRESHOLD_BASE,       24'h800000);
      write_reg(lifna_pkg::CSR_THRESHOLD_PEAK,       24'h7FFFFF);
      write_reg(UNUSED_REG_INDEX,                    24'h123456);
      csr_valid <= 1'b0;
      // conductance saturates high, then voltage swings to both rails
      repeat (6) offer_update(10'd1, 12'hFFF);
      offer_update(10'd999, 12'hFFF);
      offer_update(10'd999, 12'hFFF);
      offer_update(10'd1023, 12'hFFF);
      offer_update(10'd0, 12'd0);
      wait_drained();
   endtask

   task automatic test_low_extremes();
      write_reg(lifna_pkg::CSR_INPUT_INCREMENT,      24'h000000);
      write_reg(lifna_pkg::CSR_CONDUCTANCE_DECAY,    24'h000000);
      write_reg(lifna_pkg::CSR_LEAK_RATE,            24'h000000);
      write_reg(lifna_pkg::CSR_LEAK_POTENTIAL,       24'h800000);
      write_reg(lifna_pkg::CSR_THRESHOLD_RELAX_RATE, 24'h01FFFF);   // above one, overshoots
      write_reg(lifna_pkg::CSR_THRESHOLD_BASE,       24'h7FFFFF);
      write_reg(lifna_pkg::CSR_THRESHOLD_PEAK,       24'h800000);
      csr_valid <= 1'b0;
      offer_update(10'd1, 12'd0);
      offer_update(10'd1, 12'hFFF);
      offer_update(10'd2, 12'd0);
      offer_update(10'd999, 12'hFFF);
      offer_update(10'd1000, 12'd0);
      wait_drained();
   endtask

   // settings in the usual biological range so that neurons charge and fire
   task automatic program_typical();
      program_regs($urandom_range(0, 16384),
                   $urandom_range(32768, 65536),
                   $urandom_range(0, 8192),
                   -($urandom_range(50, 75) << lifna_pkg::Q_FRAC),
                   $urandom_range(0, 8192),
                   -($urandom_range(40, 55) << lifna_pkg::Q_FRAC),
                   int'($urandom_range(0, 30) << lifna_pkg::Q_FRAC)
                   - (10 << lifna_pkg::Q_FRAC));
   endtask

   // unless wide is set, most requests hit a small group of neurons, the rest are anywhere
   task automatic test_random_traffic(input int items, input bit wide);
      int                            group_base;
      logic [lifna_pkg::INDEX_W-1:0] idx;
      logic [lifna_pkg::COUNT_W-1:0] cnt;
      group_base = $urandom_range(0, NEURONS - 16);
      for (int n = 0; n < items; n++) begin
         if (n % 64 == 0) begin
            req_gaps   = ($urandom_range(0, 3) != 0);
            rsp_stalls = ($urandom_range(0, 3) != 0);
         end
         if (wide || $urandom_range(0, 9) == 0) begin
            idx = lifna_pkg::INDEX_W'($urandom_range(0, 1023));
            cnt = lifna_pkg::COUNT_W'($urandom_range(0, 4095));
         end else begin
            idx = lifna_pkg::INDEX_W'(group_base + int'($urandom_range(0, 15)));
            cnt = lifna_pkg::COUNT_W'(($urandom_range(0, 19) == 0) ? $urandom_range(0, 4095)
                                                                    : $urandom_range(0, 12));
         end
         offer_update(idx, cnt);
      end
      wait_drained();
   endtask

   // long response hold-off while requests keep coming
   task automatic test_backpressure();
      req_gaps     = 1'b0;
      hold_request = 1'b1;
      for (int n = 0; n < 40; n++)
         offer_update(lifna_pkg::INDEX_W'($urandom_range(0, 15)),
                      lifna_pkg::COUNT_W'($urandom_range(0, 12)));
      wait_drained();
   endtask

   initial begin
      clear_neuron_state();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_high_extremes();
      test_low_extremes();

      req_gaps   = 1'b1;
      rsp_stalls = 1'b1;
      program_typical();
      test_random_traffic(300, 1'b0);

      test_backpressure();

      // every register bit, above-range fractions included
      program_regs($urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF),
                   $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF),
                   $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF),
                   $urandom_range(0, 24'hFFFFFF));
      test_random_traffic(250, 1'b1);

      // extremes of the stated ranges
      program_regs(65536, 65536, 65536, 8388607, 65536, -8388608, 8388607);
      test_random_traffic(150, 1'b0);

      program_typical();
      test_random_traffic(300, 1'b0);

      // closing stretch runs at full rate on both sides
      program_typical();
      req_gaps   = 1'b0;
      rsp_stalls = 1'b0;
      for (int n = 0; n < 200; n++)
         offer_update(lifna_pkg::INDEX_W'($urandom_range(0, 31)),
                      lifna_pkg::COUNT_W'($urandom_range(0, 12)));
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("lif_neuron_adaptive_threshold_unit: match");
      end else begin
         $display("lif_neuron_adaptive_threshold_unit: mismatch");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/lifna_pkg.sv
rtl/core/lifna_ram.sv
rtl/core/lif_neuron_adaptive_threshold_unit.sv
rtl/core/lifna_checker.sv
dv/tb_lif_neuron_adaptive_threshold_unit.sv
